### hw/rtl/heat_diffusion_stencil_pass_macros.svh
// assertion macros shared by the stencil rtl
`ifndef HEAT_DIFFUSION_STENCIL_PASS_MACROS_SVH
`define HEAT_DIFFUSION_STENCIL_PASS_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define HDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hds_pkg.sv
// types and constants of the heat diffusion stencil pass
package hds_pkg;

  localparam int VAL_W     = 16;
  localparam int COORD_W   = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // (a + 4*b + c + 3) of three 16-bit values fits in 19 bits
  localparam int SUM_W  = 19;
  // x / 6 == (x * ceil(2^21 / 6)) >> 21 for every x below 2^19
  localparam int DIV6_SHIFT = 21;
  localparam logic [SUM_W-1:0] DIV6_MUL = 19'd349526;
  localparam int PROD_W = 2 * SUM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_ROW_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_ROW_LAST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_COL_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_COL_LAST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_VALUE     = 3'd5;

  localparam logic [COORD_W-1:0] GRID_SIDE_RST = 9'd256;
  localparam logic [COORD_W-1:0] HOT_FIRST_RST = 9'd1;
  localparam logic [COORD_W-1:0] HOT_LAST_RST  = 9'd0;
  localparam logic [VAL_W-1:0]   HOT_VALUE_RST = 16'd32768;

  typedef struct packed {
    logic [VAL_W-1:0] cell_value;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0]   new_value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               frame_last;
  } out_t;

  // per-cell control that rides along the pipeline
  typedef struct packed {
    logic               vact;
    logic               vint;
    logic               emit;
    logic               hot;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } stage_ctl_t;

endpackage

### hw/rtl/heat_diffusion_stencil_pass.sv
// One Jacobi step of 3x3 separable heat diffusion over a raster-streamed grid.
// Takes one cell per clock while in_ready is high, border ring included,
// and emits one beat per interior cell once its right neighbor column has
// arrived. Throughput is one cell per cycle while the skid is empty, set by
// the two line stores, each doing one read and one write per cycle; results
// pass address and read, vertical sum, divide, horizontal sum, divide and the
// output register. A skid register behind it parks one result while the sink
// stalls; input waits only while the skid is full. Line store entries carry no
// reset and hold whatever was last written; configure only while idle.
`include "heat_diffusion_stencil_pass_macros.svh"

module heat_diffusion_stencil_pass #(
  parameter int MAX_SIDE = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  hds_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output hds_pkg::out_t                       out_data,
  input  logic                                cfg_write,
  input  logic [hds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hds_pkg::CFG_DAT_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_SIDE + 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_SIDE + 3);
  localparam int XW    = (CW > hds_pkg::COORD_W) ? CW : hds_pkg::COORD_W;
  localparam int VW    = hds_pkg::VAL_W;
  localparam int SW    = hds_pkg::SUM_W;
  localparam int PW    = hds_pkg::PROD_W;
  localparam int KW    = hds_pkg::COORD_W;

  // configuration
  logic [KW-1:0] grid_side;
  logic [KW-1:0] hot_row_first;
  logic [KW-1:0] hot_row_last;
  logic [KW-1:0] hot_col_first;
  logic [KW-1:0] hot_col_last;
  logic [VW-1:0] hot_value;

  // frame position
  logic [CW-1:0] row_cnt;
  logic [CW-1:0] col_cnt;
  logic [CW-1:0] row_cur;
  logic [CW-1:0] col_cur;
  logic [CW-1:0] row_cnt_next;
  logic [CW-1:0] col_cnt_next;
  logic [CW-1:0] col_inc;
  logic [CW-1:0] row_inc;
  logic [CW-1:0] side;
  logic [CW-1:0] frame;
  logic [CW-1:0] r_cur;
  logic [CW-1:0] c_cur;
  logic [XW-1:0] r_x;
  logic [XW-1:0] c_x;
  hds_pkg::stage_ctl_t ctl_in;

  logic adv;
  logic acc;

  // line stores
  logic [VW-1:0] upper_mem [DEPTH];
  logic [VW-1:0] lower_mem [DEPTH];
  logic [VW-1:0] up_rd;
  logic [VW-1:0] mid_rd;

  // stage 1: read data and forwarding
  logic                s1_valid;
  hds_pkg::stage_ctl_t s1_ctl;
  logic [AW-1:0]       s1_addr;
  logic [VW-1:0]       s1_cell;
  logic                fwd;
  logic [VW-1:0]       fwd_up;
  logic [VW-1:0]       fwd_mid;
  logic [VW-1:0]       up_e;
  logic [VW-1:0]       mid_e;
  logic [SW-1:0]       vsum;

  // stage 2: vertical sum
  logic                s2_valid;
  hds_pkg::stage_ctl_t s2_ctl;
  logic [SW-1:0]       s2_sum;
  logic [VW-1:0]       s2_mid;

  // stage 3: vertical quotient and window
  logic                s3_valid;
  hds_pkg::stage_ctl_t s3_ctl;
  logic [PW-1:0]       s3_prod;
  logic [VW-1:0]       s3_mid;
  logic [VW-1:0]       smoothed;
  logic [VW-1:0]       win_a;
  logic [VW-1:0]       win_b;
  logic [SW-1:0]       hsum;

  // stage 4: horizontal sum
  logic                s4_valid;
  hds_pkg::stage_ctl_t s4_ctl;
  logic [SW-1:0]       s4_sum;

  // stage 5: horizontal quotient
  logic                s5_valid;
  hds_pkg::stage_ctl_t s5_ctl;
  logic [PW-1:0]       s5_prod;
  hds_pkg::out_t       res;
  logic                res_v;

  // output register and skid
  logic          skid_valid;
  hds_pkg::out_t skid_data;

  assign adv      = !skid_valid;
  assign in_ready = adv;
  assign acc      = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side     <= hds_pkg::GRID_SIDE_RST;
      hot_row_first <= hds_pkg::HOT_FIRST_RST;
      hot_row_last  <= hds_pkg::HOT_LAST_RST;
      hot_col_first <= hds_pkg::HOT_FIRST_RST;
      hot_col_last  <= hds_pkg::HOT_LAST_RST;
      hot_value     <= hds_pkg::HOT_VALUE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        hds_pkg::CFG_GRID_SIDE:     grid_side     <= cfg_data[KW-1:0];
        hds_pkg::CFG_HOT_ROW_FIRST: hot_row_first <= cfg_data[KW-1:0];
        hds_pkg::CFG_HOT_ROW_LAST:  hot_row_last  <= cfg_data[KW-1:0];
        hds_pkg::CFG_HOT_COL_FIRST: hot_col_first <= cfg_data[KW-1:0];
        hds_pkg::CFG_HOT_COL_LAST:  hot_col_last  <= cfg_data[KW-1:0];
        hds_pkg::CFG_HOT_VALUE:     hot_value     <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  // position of the incoming cell and the classification of its stencil
  always_comb begin
    if (32'(grid_side) > MAX_SIDE) begin
      side = CW'(MAX_SIDE);
    end else if (grid_side == '0) begin
      side = CW'(1);
    end else begin
      side = CW'(grid_side);
    end
    frame = side + CW'(2);

    row_cur = in_data.frame_start ? '0 : row_cnt;
    col_cur = in_data.frame_start ? '0 : col_cnt;

    col_inc = col_cur + CW'(1);
    row_inc = row_cur + CW'(1);
    if (col_inc >= frame) begin
      col_cnt_next = '0;
      row_cnt_next = (row_inc >= frame) ? '0 : row_inc;
    end else begin
      col_cnt_next = col_inc;
      row_cnt_next = (row_cur >= frame) ? '0 : row_cur;
    end

    r_cur = row_cur - CW'(1);
    c_cur = col_cur - CW'(1);
    r_x   = XW'(r_cur);
    c_x   = XW'(c_cur);

    ctl_in.vact = (row_cur >= CW'(2)) && (row_cur < frame);
    ctl_in.vint = (col_cur >= CW'(1)) && (col_cur <= side);
    ctl_in.emit = ctl_in.vact && (col_cur >= CW'(2)) && (col_cur < frame);
    ctl_in.hot  = (r_x >= XW'(hot_row_first)) && (r_x <= XW'(hot_row_last)) &&
                  (c_x >= XW'(hot_col_first)) && (c_x <= XW'(hot_col_last));
    ctl_in.last = (r_cur == side) && (c_cur == side);
    ctl_in.row  = KW'(r_cur);
    ctl_in.col  = KW'(c_cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (acc) begin
      row_cnt <= row_cnt_next;
      col_cnt <= col_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      up_rd  <= upper_mem[col_cur[AW-1:0]];
      mid_rd <= lower_mem[col_cur[AW-1:0]];
    end
    if (adv && s1_valid) begin
      upper_mem[s1_addr] <= mid_e;
      lower_mem[s1_addr] <= s1_cell;
    end
  end

  // the cell in stage 1 writes its column on the same edge the next one reads
  assign up_e  = fwd ? fwd_up  : up_rd;
  assign mid_e = fwd ? fwd_mid : mid_rd;
  assign vsum  = SW'(up_e) + {1'b0, mid_e, 2'b00} + SW'(s1_cell) + SW'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl  <= ctl_in;
      s1_addr <= col_cur[AW-1:0];
      s1_cell <= in_data.cell_value;
      fwd     <= s1_valid && (s1_addr == col_cur[AW-1:0]);
      fwd_up  <= mid_e;
      fwd_mid <= s1_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid && s3_ctl.emit;
      s5_valid <= s4_valid;
    end
  end

  assign smoothed = s3_ctl.vint ? s3_prod[hds_pkg::DIV6_SHIFT +: VW] : s3_mid;
  assign hsum     = SW'(win_a) + {1'b0, win_b, 2'b00} + SW'(smoothed) + SW'(3);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl  <= s1_ctl;
      s2_sum  <= vsum;
      s2_mid  <= mid_e;
      s3_ctl  <= s2_ctl;
      s3_prod <= PW'(s2_sum) * PW'(hds_pkg::DIV6_MUL);
      s3_mid  <= s2_mid;
      s4_ctl  <= s3_ctl;
      s4_sum  <= hsum;
      s5_ctl  <= s4_ctl;
      s5_prod <= PW'(s4_sum) * PW'(hds_pkg::DIV6_MUL);
    end
  end

  // window of vertically smoothed values, left to right
  always_ff @(posedge clk) begin
    if (rst) begin
      win_a <= '0;
      win_b <= '0;
    end else if (adv && s3_valid && s3_ctl.vact) begin
      win_a <= win_b;
      win_b <= smoothed;
    end
  end

  always_comb begin
    res.new_value  = s5_ctl.hot ? hot_value : s5_prod[hds_pkg::DIV6_SHIFT +: VW];
    res.out_row    = s5_ctl.row;
    res.out_col    = s5_ctl.col;
    res.frame_last = s5_ctl.last;
  end

  assign res_v = adv && s5_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_v;
      end
    end else if (res_v) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (res_v) begin
      skid_data <= res;
    end
  end

  `HDS_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
    "skid holds a beat while the output register is empty")
  `HDS_ASSERT_NEXT(a_stalled_beat_kept, res_v && out_valid && !out_ready, skid_valid,
    "result produced into a stalled output was not parked in the skid")
  `HDS_ASSERT_NEXT(a_same_column_forward,
    acc && s1_valid && (s1_addr == col_cur[AW-1:0]), fwd,
    "back-to-back access to one column was not forwarded")
  `HDS_ASSERT_NEXT(a_position_in_store, acc, col_cnt < CW'(DEPTH),
    "column counter ran past the line store")
  `HDS_ASSERT_NOW(a_last_on_diagonal, out_valid && out_data.frame_last,
    out_data.out_row == out_data.out_col,
    "frame_last on a cell off the corner")

endmodule
